/* sv/wav_header_parser_defines.svh */
// ----------------------------------------------------------------------------
// WAV header parser assertion macros
// Clocked, reset-qualified property helpers shared by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef WAV_HEADER_PARSER_DEFINES_SVH
`define WAV_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define WHP_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wav header parser: same-cycle check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define WHP_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wav header parser: next-cycle check failed");

`endif

/* sv/whp_pkg.sv */
// ----------------------------------------------------------------------------
// WAV header parser package
// Transaction types, parser state, chunk tags and status codes.
// ----------------------------------------------------------------------------
package whp_pkg;

    typedef enum logic [2:0] {
        PH_RIFF,
        PH_CHUNK,
        PH_FMT,
        PH_SKIP,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        ST_PARSING     = 3'd0,
        ST_OK          = 3'd1,
        ST_SHORT       = 3'd2,
        ST_NOT_WAVE    = 3'd3,
        ST_BAD_SIZE    = 3'd4,
        ST_UNSUPPORTED = 3'd5,
        ST_MISSING     = 3'd6
    } t_status;

    localparam logic [31:0] C_TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] C_TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] C_TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] C_TAG_DATA = 32'h6174_6164;
    localparam logic [15:0] C_PCM_CODE = 16'h0001;
    localparam logic [15:0] C_PCM_BITS = 16'd16;
    localparam logic [15:0] C_MONO     = 16'd1;
    localparam logic [15:0] C_STEREO   = 16'd2;
    localparam logic [31:0] C_FMT_SIZE = 32'd16;

    // Byte counts within the header shift register
    localparam logic [4:0] C_MAGIC_LEN = 5'd4;
    localparam logic [4:0] C_RIFF_LEN  = 5'd12;
    localparam logic [4:0] C_CHUNK_LEN = 5'd8;
    localparam logic [4:0] C_FMT_HALF  = 5'd8;
    localparam logic [4:0] C_FMT_LEN   = 5'd16;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] chan_count;
        logic [31:0] rate_hz;
        logic [31:0] bytes_per_sec;
        logic [15:0] sample_bits;
        logic [31:0] audio_start;
        logic [31:0] audio_len;
    } t_out_item;

    typedef struct packed {
        t_phase      phase;
        logic [4:0]  hdr_cnt;
        logic [63:0] shift;
        logic [32:0] skip;
        logic [31:0] pos;
        logic        fmt_seen;
        logic [15:0] fmt_code;
        logic        magic_bad;
        t_status     final_status;
        logic [15:0] chan_count;
        logic [31:0] rate_hz;
        logic [31:0] bytes_per_sec;
        logic [15:0] sample_bits;
        logic [31:0] audio_start;
        logic [31:0] audio_len;
    } t_state;

    function automatic t_state reset_state();
        t_state s;
        s              = '0;
        s.phase        = PH_RIFF;
        s.final_status = ST_PARSING;
        return s;
    endfunction

endpackage

/* sv/wav_header_parser.sv */
// ----------------------------------------------------------------------------
// WAV header parser
// Byte-stream RIFF/WAVE header checker with fmt and data chunk decode.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_stall | data_byte, first_byte, last_byte
//  out     | output    | o_out_valid/i_out_stall | status and decoded header fields
//
//  One byte transaction is taken per cycle while o_in_stall is low; each yields exactly one result.
//  Each byte passes through the input register, then one parser step into the
//  result register, which also updates the parser state.
//  Reset (i_rst_n low, synchronous) clears the input/result valids and the
//  parser state to the start of a RIFF header.
//  A stalled result holds; the input register still takes one more byte
//  behind it, and o_in_stall rises only when both registers are full.
//
`include "wav_header_parser_defines.svh"

module wav_header_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  whp_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output whp_pkg::t_out_item o_out_data
);
    import whp_pkg::*;

    logic      move;
    logic      in_valid;
    t_in_item  in_item;
    t_state    r_st;
    t_state    n_st;
    t_out_item r_out;
    t_out_item n_out;
    logic      r_out_valid;

    // Advance the parser when a byte is registered and the result slot frees up
    assign move = in_valid && (!r_out_valid || !i_out_stall);

    whp_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_take     (move),
        .o_valid    (in_valid),
        .o_item     (in_item)
    );

    // One full parser step: first_byte clear, byte consume, end-of-file checks
    whp_step u_step (
        .i_state  (r_st),
        .i_item   (in_item),
        .o_state  (n_st),
        .o_result (n_out)
    );

    // Hold parser state between bytes; commit only on a moving transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= reset_state();
        end else if (move) begin
            r_st <= n_st;
        end
    end

    // Result register: load on move, drop valid once taken downstream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A finished parse ignores bytes until the next file starts
    `WHP_ASSERT_NXT(a_done_holds, move && r_st.phase == PH_DONE && !in_item.first_byte, $stable(r_st))
    // Skip phase is only ever entered with bytes left to skip
    `WHP_ASSERT_IMP(a_skip_nonzero, r_st.phase == PH_SKIP, r_st.skip != 33'd0)
    // Header byte count never runs past the fmt body length
    `WHP_ASSERT_IMP(a_cnt_bound, 1'b1, r_st.hdr_cnt <= C_FMT_LEN)
    // Input stalls only when its register holds an unconsumed byte
    `WHP_ASSERT_IMP(a_stall_full, o_in_stall, in_valid && r_out_valid && i_out_stall)
    // Every parser advance presents a result on the next cycle
    `WHP_ASSERT_NXT(a_move_result, move, r_out_valid)

endmodule

/* sv/whp_in_stage.sv */
// ----------------------------------------------------------------------------
// WAV header parser input stage
// Registers one input transaction and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module whp_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  whp_pkg::t_in_item i_in_data,
    output logic              o_in_stall,
    input  logic              i_take,
    output logic              o_valid,
    output whp_pkg::t_in_item o_item
);
    import whp_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // Hold while a registered transaction is waiting on the parser
    assign o_in_stall = r_valid && !i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_item <= i_in_data;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* sv/whp_step.sv */
// ----------------------------------------------------------------------------
// WAV header parser step
// Next parser state and result for one file byte.
// ----------------------------------------------------------------------------
module whp_step (
    input  whp_pkg::t_state    i_state,
    input  whp_pkg::t_in_item  i_item,
    output whp_pkg::t_state    o_state,
    output whp_pkg::t_out_item o_result
);
    import whp_pkg::*;

    t_state      cur;
    t_state      n_st;
    logic [63:0] sh;
    logic [4:0]  cnt;
    logic [31:0] size;
    logic [32:0] dec;

    assign cur  = i_item.first_byte ? reset_state() : i_state;
    assign sh   = {i_item.data_byte, cur.shift[63:8]};
    assign cnt  = cur.hdr_cnt + 5'd1;
    assign size = sh[63:32];
    assign dec  = (cur.skip != 33'd0) ? cur.skip - 33'd1 : cur.skip;

    always_comb begin
        n_st = cur;
        if (cur.phase != PH_DONE) begin
            n_st.pos = cur.pos + 32'd1;
            case (cur.phase)
                PH_RIFF: begin
                    n_st.shift   = sh;
                    n_st.hdr_cnt = cnt;
                    if (cnt == C_MAGIC_LEN && size != C_TAG_RIFF) begin
                        n_st.magic_bad = 1'b1;
                    end
                    if (cnt == C_RIFF_LEN) begin
                        n_st.hdr_cnt = '0;
                        if (n_st.magic_bad || size != C_TAG_WAVE) begin
                            n_st.final_status = ST_NOT_WAVE;
                            n_st.phase        = PH_DONE;
                        end else begin
                            n_st.phase = PH_CHUNK;
                        end
                    end
                end
                PH_CHUNK: begin
                    n_st.shift   = sh;
                    n_st.hdr_cnt = cnt;
                    if (cnt == C_CHUNK_LEN) begin
                        n_st.hdr_cnt = '0;
                        if (sh[31:0] == C_TAG_FMT) begin
                            if (size < C_FMT_SIZE) begin
                                n_st.final_status = ST_BAD_SIZE;
                                n_st.phase        = PH_DONE;
                            end else begin
                                n_st.skip  = {1'b0, size - C_FMT_SIZE} + {32'd0, size[0]};
                                n_st.phase = PH_FMT;
                            end
                        end else if (sh[31:0] == C_TAG_DATA) begin
                            n_st.audio_start = n_st.pos;
                            n_st.audio_len   = size;
                            n_st.phase       = PH_DONE;
                            if (!cur.fmt_seen) begin
                                n_st.final_status = ST_MISSING;
                            end else if (cur.sample_bits != C_PCM_BITS) begin
                                n_st.final_status = ST_UNSUPPORTED;
                            end else if (cur.chan_count != C_MONO &&
                                         cur.chan_count != C_STEREO) begin
                                n_st.final_status = ST_UNSUPPORTED;
                            end else if (cur.bytes_per_sec == 32'd0) begin
                                n_st.final_status = ST_BAD_SIZE;
                            end else begin
                                n_st.final_status = ST_OK;
                            end
                        end else begin
                            n_st.skip  = {1'b0, size} + {32'd0, size[0]};
                            n_st.phase = (size != 32'd0) ? PH_SKIP : PH_CHUNK;
                        end
                    end
                end
                PH_FMT: begin
                    n_st.shift   = sh;
                    n_st.hdr_cnt = cnt;
                    if (cnt == C_FMT_HALF) begin
                        n_st.fmt_code   = sh[15:0];
                        n_st.chan_count = sh[31:16];
                        n_st.rate_hz    = sh[63:32];
                    end else if (cnt == C_FMT_LEN) begin
                        n_st.hdr_cnt       = '0;
                        n_st.bytes_per_sec = sh[31:0];
                        n_st.sample_bits   = sh[63:48];
                        n_st.fmt_seen      = 1'b1;
                        if (cur.fmt_code != C_PCM_CODE) begin
                            n_st.final_status = ST_UNSUPPORTED;
                            n_st.phase        = PH_DONE;
                        end else begin
                            n_st.phase = (cur.skip != 33'd0) ? PH_SKIP : PH_CHUNK;
                        end
                    end
                end
                PH_SKIP: begin
                    n_st.skip = dec;
                    if (dec == 33'd0) begin
                        n_st.hdr_cnt = '0;
                        n_st.phase   = PH_CHUNK;
                    end
                end
                default: begin
                end
            endcase
            // End of file before a final code: classify where the stream stopped
            if (i_item.last_byte && n_st.phase != PH_DONE) begin
                if ((n_st.phase == PH_CHUNK && n_st.hdr_cnt == 5'd0) ||
                    n_st.phase == PH_SKIP) begin
                    n_st.final_status = ST_MISSING;
                end else begin
                    n_st.final_status = ST_SHORT;
                end
                n_st.phase = PH_DONE;
            end
        end
    end

    assign o_state = n_st;

    always_comb begin
        o_result.status        = (n_st.phase == PH_DONE) ? n_st.final_status : ST_PARSING;
        o_result.chan_count    = n_st.chan_count;
        o_result.rate_hz       = n_st.rate_hz;
        o_result.bytes_per_sec = n_st.bytes_per_sec;
        o_result.sample_bits   = n_st.sample_bits;
        o_result.audio_start   = n_st.audio_start;
        o_result.audio_len     = n_st.audio_len;
    end

endmodule
